/* hdl/decimal_period_analyzer_assert.svh */
// Assertion macros for the decimal period analyzer checker.
// Used by the bound checker module only.
`ifndef DECIMAL_PERIOD_ANALYZER_ASSERT_SVH
`define DECIMAL_PERIOD_ANALYZER_ASSERT_SVH
`define DPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/dpa_pkg.sv */
// Package for the decimal period analyzer: widths, constants, reset value.
// No dependencies.
package dpa_pkg;
    localparam int unsigned DataW  = 32;
    localparam int unsigned ModW   = 35;  // magnitudes reach 2^31; ten times a remainder needs 35 bits
    localparam int unsigned CntW   = 6;   // bit counter for serial division
    localparam int unsigned LimW   = 16;
    localparam int unsigned PreW   = 5;
    localparam logic [LimW-1:0] LimitReset = 16'd300;
endpackage

/* hdl/dpa_divider.sv */
// Bit-serial restoring divider: remainder and quotient, one bit per cycle.
// Depends on dpa_pkg.
module dpa_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dpa_pkg::ModW-1:0]    i_dividend,
    input  logic [dpa_pkg::ModW-1:0]    i_divisor,
    output logic                        o_done,
    output logic [dpa_pkg::ModW-1:0]    o_quot,
    output logic [dpa_pkg::ModW-1:0]    o_rem
);
    logic [dpa_pkg::ModW-1:0] r_quot, r_rem, r_div;
    logic [dpa_pkg::CntW-1:0] r_cnt;
    logic                     r_busy, r_done;
    logic [dpa_pkg::ModW:0]   n_trial;

    assign n_trial = {r_rem, r_quot[dpa_pkg::ModW-1]} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= dpa_pkg::CntW'(dpa_pkg::ModW);
            end else if (r_busy) begin
                if (!n_trial[dpa_pkg::ModW]) begin
                    r_rem  <= n_trial[dpa_pkg::ModW-1:0];
                    r_quot <= {r_quot[dpa_pkg::ModW-2:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[dpa_pkg::ModW-2:0], r_quot[dpa_pkg::ModW-1]};
                    r_quot <= {r_quot[dpa_pkg::ModW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == dpa_pkg::CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

/* hdl/decimal_period_analyzer.sv */
// Top level of the decimal period analyzer: control sequencer and result register.
// Depends on dpa_pkg and dpa_divider.
//
// Usage: an item (numerator, denominator) enters on i_valid/o_stall; the
// block stalls its input while it works on one item. The result
// (preperiod length, period length) appears on o_valid and holds while
// i_stall is high; the next item is taken the cycle after the result moves.
// Every remainder or quotient but the halving of factors of 2 comes from
// one shared bit-serial divider; a zero denominator gives its result in
// the cycle after the item is taken. The order search runs up to
// period_limit steps.
// The period_limit register (reset 300) is written through i_cfg_valid /
// o_cfg_ready while the block is idle. Synchronous active-low reset
// returns the block to idle and the limit to 300; a held result is lost.
module decimal_period_analyzer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [dpa_pkg::DataW-1:0] i_numerator,
    input  logic signed [dpa_pkg::DataW-1:0] i_denominator,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dpa_pkg::PreW-1:0]      o_preperiod_len,
    output logic [dpa_pkg::LimW-1:0]      o_period_len,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dpa_pkg::LimW-1:0]      i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_GCD, S_GCD_W, S_RED, S_RED_W, S_TWO, S_TWO_W,
        S_FIVE, S_FIVE_W, S_ORD, S_ORD_W, S_OUT
    } t_state;

    t_state r_state;
    logic [dpa_pkg::ModW-1:0] r_x, r_y, r_d, r_m, r_r;
    logic [dpa_pkg::PreW-1:0] r_twos, r_fives;
    logic [dpa_pkg::LimW-1:0] r_len, r_limit;
    logic [dpa_pkg::PreW-1:0] r_pre_out;
    logic [dpa_pkg::LimW-1:0] r_per_out;
    logic                     r_div_start;
    logic [dpa_pkg::ModW-1:0] r_dvd, r_dvs;
    logic                     div_done;
    logic [dpa_pkg::ModW-1:0] div_quot, div_rem;
    logic [dpa_pkg::ModW-1:0] n_nmag, n_dmag;
    logic [dpa_pkg::PreW-1:0] n_pre;

    function automatic logic [dpa_pkg::ModW-1:0] mag(input logic [dpa_pkg::DataW-1:0] v);
        logic [dpa_pkg::ModW-1:0] e;
        e = {{(dpa_pkg::ModW-dpa_pkg::DataW){1'b0}}, v};
        if (v[dpa_pkg::DataW-1])
            return (dpa_pkg::ModW'(1) << dpa_pkg::DataW) - e;
        return e;
    endfunction

    assign n_nmag = mag(i_numerator);
    assign n_dmag = mag(i_denominator);
    assign n_pre  = (r_twos > r_fives) ? r_twos : r_fives;

    dpa_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_dividend(r_dvd), .i_divisor(r_dvs),
        .o_done(div_done), .o_quot(div_quot), .o_rem(div_rem)
    );

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_preperiod_len = r_pre_out;
    assign o_period_len    = r_per_out;
    assign o_cfg_ready     = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= dpa_pkg::LimitReset;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid)
                        r_limit <= i_cfg_data;
                    if (i_valid) begin
                        r_x       <= n_nmag;
                        r_y       <= n_dmag;
                        r_d       <= n_dmag;
                        r_twos    <= '0;
                        r_fives   <= '0;
                        r_pre_out <= '0;
                        r_per_out <= '0;
                        if (n_dmag == '0)
                            r_state <= S_OUT;
                        else
                            r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_y == '0) begin
                        // g = x (never 0 here since d != 0)
                        r_dvd <= r_d;
                        r_dvs <= r_x;
                        r_div_start <= 1'b1;
                        r_state <= S_RED_W;
                    end else begin
                        r_dvd <= r_x;
                        r_dvs <= r_y;
                        r_div_start <= 1'b1;
                        r_state <= S_GCD_W;
                    end
                end
                S_GCD_W: begin
                    if (div_done) begin
                        r_x <= r_y;
                        r_y <= div_rem;
                        r_state <= S_GCD;
                    end
                end
                S_RED_W: begin
                    if (div_done) begin
                        r_m <= div_quot;
                        if (div_quot <= dpa_pkg::ModW'(1))
                            r_state <= S_OUT;
                        else
                            r_state <= S_TWO;
                    end
                end
                S_RED: r_state <= S_OUT;
                S_TWO: begin
                    // factors of 2 strip by shift
                    if (!r_m[0]) begin
                        r_m    <= r_m >> 1;
                        r_twos <= r_twos + 1'b1;
                    end else
                        r_state <= S_FIVE;
                end
                S_TWO_W: r_state <= S_OUT;
                S_FIVE: begin
                    r_dvd <= r_m;
                    r_dvs <= dpa_pkg::ModW'(5);
                    r_div_start <= 1'b1;
                    r_state <= S_FIVE_W;
                end
                S_FIVE_W: begin
                    if (div_done) begin
                        if (div_rem == '0) begin
                            r_m     <= div_quot;
                            r_fives <= r_fives + 1'b1;
                            r_state <= S_FIVE;
                        end else begin
                            r_pre_out <= n_pre;
                            if (r_m == dpa_pkg::ModW'(1))
                                r_state <= S_OUT;
                            else begin
                                r_dvd <= dpa_pkg::ModW'(10);
                                r_dvs <= r_m;
                                r_div_start <= 1'b1;
                                r_len <= dpa_pkg::LimW'(1);
                                r_state <= S_ORD_W;
                            end
                        end
                    end
                end
                S_ORD_W: begin
                    if (div_done) begin
                        r_r <= div_rem;
                        r_state <= S_ORD;
                    end
                end
                S_ORD: begin
                    if (r_r == dpa_pkg::ModW'(1)) begin
                        r_per_out <= r_len;
                        r_state <= S_OUT;
                    end else if (r_len >= r_limit) begin
                        r_per_out <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // r < m < 2^31, so r*10 fits in 35 bits; use (r<<3)+(r<<1) mod m
                        r_dvd <= (r_r << 3) + (r_r << 1);
                        r_dvs <= r_m;
                        r_div_start <= 1'b1;
                        r_len <= r_len + 1'b1;
                        r_state <= S_ORD_W;
                    end
                end
                S_OUT: begin
                    if (!i_stall)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/decimal_period_analyzer_checker.sv */
// Port-level checker for the decimal period analyzer, bound to the top level.
// Depends on dpa_pkg and decimal_period_analyzer_assert.svh.
`include "decimal_period_analyzer_assert.svh"
module decimal_period_analyzer_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [dpa_pkg::PreW-1:0] o_preperiod_len,
    input logic [dpa_pkg::LimW-1:0] o_period_len,
    input logic                     o_cfg_ready
);
    `DPA_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_period_len) && $stable(o_preperiod_len))
    `DPA_ASSERT_IMPL(a_busy_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `DPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `DPA_ASSERT_IMPL(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, !o_stall)
endmodule

bind decimal_period_analyzer decimal_period_analyzer_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_preperiod_len(o_preperiod_len),
    .o_period_len(o_period_len), .o_cfg_ready(o_cfg_ready)
);
